/* hdl/spd_pkg.sv */
// Shared types, constants and register codes for the sector proximity detector.
package spd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int SQ_BITS            = 32;
   localparam int DIST_BITS          = 16;
   localparam int CSR_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [SQ_BITS-1:0] SQ_NONE = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRONT_OBSTACLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_OBSTACLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRASH          = 2'd2;

   localparam logic [CSR_BITS-1:0] FRONT_OBSTACLE_RESET = 16'd1000;
   localparam logic [CSR_BITS-1:0] RIGHT_OBSTACLE_RESET = 16'd1500;
   localparam logic [CSR_BITS-1:0] CRASH_RESET          = 16'd400;

   // Per-sector minimum squared distances of one finished frame.
   typedef struct packed {
      logic [SQ_BITS-1:0] front_sq;
      logic [SQ_BITS-1:0] right_sq;
      logic [SQ_BITS-1:0] left_sq;
   } frame_type;

   // Threshold settings as written by software.
   typedef struct packed {
      logic [CSR_BITS-1:0] front_obstacle_mm;
      logic [CSR_BITS-1:0] right_obstacle_mm;
      logic [CSR_BITS-1:0] crash_mm;
   } thresholds_type;

   // Status flags of the frame queue for its producer and its consumer.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

/* hdl/spd_front.sv */
// Point pipeline: sector classification, squared distance and per-sector minima.
module spd_front
   import spd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_frame_end,
   output logic                         q_push,
   output frame_type                    q_push_data,
   input  logic                         q_full
);

   localparam int SQR_BITS = 2 * COORD_BITS;
   localparam int SUM_BITS = SQR_BITS + 2;

   localparam logic [1:0] SECTOR_NONE  = 2'd0;
   localparam logic [1:0] SECTOR_FRONT = 2'd1;
   localparam logic [1:0] SECTOR_RIGHT = 2'd2;
   localparam logic [1:0] SECTOR_LEFT  = 2'd3;

   logic                         stall;

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic                         s1_last_ff;

   logic [COORD_BITS-1:0]        abs_x, abs_y, abs_z;
   logic                         ahead, to_right;
   logic [1:0]                   sector;

   logic                         s2_valid_ff;
   logic [SQR_BITS-1:0]          s2_sq_x_ff, s2_sq_y_ff, s2_sq_z_ff;
   logic [1:0]                   s2_sector_ff;
   logic                         s2_last_ff;

   logic [SUM_BITS-1:0]          sum;
   logic [SQ_BITS-1:0]           sum_sat;

   logic                         s3_valid_ff;
   logic [SQ_BITS-1:0]           s3_sq_ff;
   logic [1:0]                   s3_sector_ff;
   logic                         s3_last_ff;

   logic [SQ_BITS-1:0]           front_min_ff, front_min_in;
   logic [SQ_BITS-1:0]           right_min_ff, right_min_in;
   logic [SQ_BITS-1:0]           left_min_ff, left_min_in;
   logic [SQ_BITS-1:0]           front_next, right_next, left_next;

   // The whole pipeline holds while a frame end waits for room in the queue.
   assign stall     = s3_valid_ff && s3_last_ff && q_full;
   assign req_ready = !stall;
   assign s1_valid_in = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_x_ff      <= req_pos_x;
         s1_y_ff      <= req_pos_y;
         s1_z_ff      <= req_pos_z;
         s1_last_ff   <= req_frame_end;
         s2_sq_x_ff   <= SQR_BITS'(abs_x) * SQR_BITS'(abs_x);
         s2_sq_y_ff   <= SQR_BITS'(abs_y) * SQR_BITS'(abs_y);
         s2_sq_z_ff   <= SQR_BITS'(abs_z) * SQR_BITS'(abs_z);
         s2_sector_ff <= sector;
         s2_last_ff   <= s1_last_ff;
         s3_sq_ff     <= sum_sat;
         s3_sector_ff <= s2_sector_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   always_comb begin
      abs_x = s1_x_ff[COORD_BITS-1] ? COORD_BITS'(-s1_x_ff) : COORD_BITS'(s1_x_ff);
      abs_y = s1_y_ff[COORD_BITS-1] ? COORD_BITS'(-s1_y_ff) : COORD_BITS'(s1_y_ff);
      abs_z = s1_z_ff[COORD_BITS-1] ? COORD_BITS'(-s1_z_ff) : COORD_BITS'(s1_z_ff);
      ahead    = !s1_y_ff[COORD_BITS-1] && (s1_y_ff != '0);
      to_right = !s1_x_ff[COORD_BITS-1] && (s1_x_ff != '0);
      priority if (!ahead) begin
         sector = SECTOR_NONE;
      end else if (abs_x < abs_y) begin
         sector = SECTOR_FRONT;
      end else if (to_right) begin
         sector = SECTOR_RIGHT;
      end else begin
         sector = SECTOR_LEFT;
      end
   end

   assign sum = SUM_BITS'(s2_sq_x_ff) + SUM_BITS'(s2_sq_y_ff) + SUM_BITS'(s2_sq_z_ff);

   generate
      if (SUM_BITS > SQ_BITS) begin : g_saturate
         assign sum_sat = (|sum[SUM_BITS-1:SQ_BITS]) ? SQ_NONE : sum[SQ_BITS-1:0];
      end else begin : g_fits
         assign sum_sat = SQ_BITS'(sum);
      end
   endgenerate

   always_comb begin
      front_next = front_min_ff;
      right_next = right_min_ff;
      left_next  = left_min_ff;
      unique case (s3_sector_ff)
         SECTOR_FRONT: if (s3_sq_ff < front_min_ff) front_next = s3_sq_ff;
         SECTOR_RIGHT: if (s3_sq_ff < right_min_ff) right_next = s3_sq_ff;
         SECTOR_LEFT:  if (s3_sq_ff < left_min_ff)  left_next  = s3_sq_ff;
         default: ;
      endcase

      front_min_in = front_min_ff;
      right_min_in = right_min_ff;
      left_min_in  = left_min_ff;
      if (s3_valid_ff && !stall) begin
         if (s3_last_ff) begin
            front_min_in = SQ_NONE;
            right_min_in = SQ_NONE;
            left_min_in  = SQ_NONE;
         end else begin
            front_min_in = front_next;
            right_min_in = right_next;
            left_min_in  = left_next;
         end
      end
   end

   assign q_push               = s3_valid_ff && s3_last_ff && !q_full;
   assign q_push_data.front_sq = front_next;
   assign q_push_data.right_sq = right_next;
   assign q_push_data.left_sq  = left_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_min_ff <= SQ_NONE;
         right_min_ff <= SQ_NONE;
         left_min_ff  <= SQ_NONE;
      end else begin
         front_min_ff <= front_min_in;
         right_min_ff <= right_min_in;
         left_min_ff  <= left_min_in;
      end
   end

endmodule

/* hdl/spd_queue.sv */
// Short queue of finished frame minima between the point pipeline and the result stage.
module spd_queue
   import spd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_data,
   input  logic             pop,
   output frame_type        head,
   output queue_status_type status
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(QUEUE_DEPTH);

   frame_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/spd_isqrt.sv */
// Floor square root of a 32-bit value, two radicand bits per clock.
module spd_isqrt
   import spd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_BITS-1:0]   operand,
   output logic                 done,
   output logic [DIST_BITS-1:0] root
);

   localparam int REM_BITS  = DIST_BITS + 2;
   localparam int WIDE_BITS = REM_BITS + 2;
   localparam int CNT_BITS  = $clog2(DIST_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIST_BITS - 1);

   logic [SQ_BITS-1:0]   rad_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [DIST_BITS-1:0] root_ff;
   logic [CNT_BITS-1:0]  step_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [WIDE_BITS-1:0] rem_shift, trial;
   logic                 take;

   assign rem_shift = {rem_ff, rad_ff[SQ_BITS-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[SQ_BITS-3:0], 2'b00};
         rem_ff  <= take ? REM_BITS'(rem_shift - trial) : REM_BITS'(rem_shift);
         root_ff <= {root_ff[DIST_BITS-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hdl/spd_back.sv */
// Result stage: pops frame minima, takes square roots, sets the flags and holds the word.
module spd_back
   import spd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  thresholds_type       thresholds,
   input  frame_type            q_head,
   input  queue_status_type     q_status,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DIST_BITS-1:0] rsp_front_distance,
   output logic [DIST_BITS-1:0] rsp_right_distance,
   output logic [DIST_BITS-1:0] rsp_left_range,
   output logic                 rsp_obstacle,
   output logic                 rsp_collision_near
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_HAND = 2'd2;

   localparam logic [1:0] SEL_FRONT = 2'd0;
   localparam logic [1:0] SEL_RIGHT = 2'd1;
   localparam logic [1:0] SEL_LEFT  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           sel_ff, sel_in;
   frame_type            snap_ff;
   logic [SQ_BITS-1:0]   front_thr_sq_ff, right_thr_sq_ff, crash_sq_ff;
   logic                 obstacle_ff, crash_ff;
   logic [DIST_BITS-1:0] front_dist_ff, right_dist_ff, left_dist_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [DIST_BITS-1:0] out_front_ff, out_right_ff, out_left_ff;
   logic                 out_obstacle_ff, out_crash_ff;

   logic                 root_start, root_done, out_load;
   logic [SQ_BITS-1:0]   root_operand;
   logic [DIST_BITS-1:0] root_value;

   spd_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (root_operand),
      .done    (root_done),
      .root    (root_value)
   );

   // Threshold squares are registered and follow the settings in the cycle after a change.
   always_ff @(posedge clock) begin
      front_thr_sq_ff <= SQ_BITS'(thresholds.front_obstacle_mm) *
                         SQ_BITS'(thresholds.front_obstacle_mm);
      right_thr_sq_ff <= SQ_BITS'(thresholds.right_obstacle_mm) *
                         SQ_BITS'(thresholds.right_obstacle_mm);
      crash_sq_ff     <= SQ_BITS'(thresholds.crash_mm) * SQ_BITS'(thresholds.crash_mm);
   end

   assign q_pop    = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_load = (state_ff == ST_HAND) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      root_start   = 1'b0;
      root_operand = q_head.front_sq;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               root_start = 1'b1;
               sel_in     = SEL_FRONT;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            root_operand = (sel_ff == SEL_FRONT) ? snap_ff.right_sq : snap_ff.left_sq;
            if (root_done) begin
               if (sel_ff == SEL_LEFT) begin
                  state_in = ST_HAND;
               end else begin
                  root_start = 1'b1;
                  sel_in     = sel_ff + 1'b1;
               end
            end
         end
         ST_HAND: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_FRONT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         snap_ff     <= q_head;
         obstacle_ff <= (q_head.front_sq < front_thr_sq_ff) ||
                        (q_head.right_sq < right_thr_sq_ff);
         crash_ff    <= (q_head.front_sq < crash_sq_ff) || (q_head.right_sq < crash_sq_ff);
      end
      if ((state_ff == ST_ROOT) && root_done) begin
         unique case (sel_ff)
            SEL_FRONT: front_dist_ff <= root_value;
            SEL_RIGHT: right_dist_ff <= root_value;
            default:   left_dist_ff  <= root_value;
         endcase
      end
      if (out_load) begin
         out_front_ff    <= front_dist_ff;
         out_right_ff    <= right_dist_ff;
         out_left_ff     <= left_dist_ff;
         out_obstacle_ff <= obstacle_ff;
         out_crash_ff    <= crash_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_front_distance = out_front_ff;
   assign rsp_right_distance = out_right_ff;
   assign rsp_left_range     = out_left_ff;
   assign rsp_obstacle       = out_obstacle_ff;
   assign rsp_collision_near = out_crash_ff;

endmodule

/* hdl/sector_proximity_detector.sv */
// Top level of the sector proximity detector: settings registers and the front, queue and back.
//
// Points stream in one word per clock while req_ready is high; each point ahead of the
// sensor is sorted into the front, right or left sector and the smallest squared distance
// per sector is kept. A word with frame_end set closes the frame: once it has passed stages
// s1, s2 and s3 its three minima enter a two-entry queue, and the result stage turns them
// into one result word with three 16-step square roots on one shared root unit, plus pop
// and handoff. The point side keeps taking one word per cycle as long as the queue has
// room, so long frames sustain full rate; short frames wait on the root unit. Distances are
// floor square roots in millimetres, 65535 for a sector that saw no point. Settings are
// written through the csr_ port and must only change while no frame is in flight.
module sector_proximity_detector
   import spd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_frame_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DIST_BITS-1:0]         rsp_front_distance,
   output logic [DIST_BITS-1:0]         rsp_right_distance,
   output logic [DIST_BITS-1:0]         rsp_left_range,
   output logic                         rsp_obstacle,
   output logic                         rsp_collision_near,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_BITS-1:0]          csr_write_data
);

   thresholds_type   thresholds_ff, thresholds_in;
   logic             q_push, q_pop;
   frame_type        q_push_data, q_head;
   queue_status_type q_status;

   always_comb begin
      thresholds_in = thresholds_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRONT_OBSTACLE: thresholds_in.front_obstacle_mm = csr_write_data;
            CSR_RIGHT_OBSTACLE: thresholds_in.right_obstacle_mm = csr_write_data;
            CSR_CRASH:          thresholds_in.crash_mm          = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.front_obstacle_mm <= FRONT_OBSTACLE_RESET;
         thresholds_ff.right_obstacle_mm <= RIGHT_OBSTACLE_RESET;
         thresholds_ff.crash_mm          <= CRASH_RESET;
      end else begin
         thresholds_ff <= thresholds_in;
      end
   end

   spd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_frame_end (req_frame_end),
      .q_push        (q_push),
      .q_push_data   (q_push_data),
      .q_full        (q_status.full)
   );

   spd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   spd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .thresholds         (thresholds_ff),
      .q_head             (q_head),
      .q_status           (q_status),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_front_distance (rsp_front_distance),
      .rsp_right_distance (rsp_right_distance),
      .rsp_left_range     (rsp_left_range),
      .rsp_obstacle       (rsp_obstacle),
      .rsp_collision_near (rsp_collision_near)
   );

endmodule
